// ===== src/desx_pkg.sv =====
// Package for the DESX cipher: permutation tables, S-boxes and round helpers.
`timescale 1ns / 1ps

package desx_pkg;

    localparam int NUM_ROUNDS = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRE_KEY  = 2'd0;
    localparam logic [1:0] CFG_DES_KEY  = 2'd1;
    localparam logic [1:0] CFG_POST_KEY = 2'd2;
    localparam logic [1:0] CFG_MODE     = 2'd3;

    localparam logic [6:0] PC1_TAB [0:55] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
        7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [6:0] PC2_TAB [0:47] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
        7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
        7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    localparam logic [6:0] IP_TAB [0:63] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [0:63] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] EXP_TAB [0:47] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [0:31] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // Total left rotation of C and D after each round
    localparam logic [4:0] ROT_SUM_TAB [0:15] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    localparam logic [3:0] SBOX_TAB [0:7][0:63] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
    };

    // Table position 1 is the top bit of the source word
    function automatic logic [63:0] ip_perm(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63 - i] = x[64 - int'(IP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [63:0] fp_perm(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63 - i] = x[64 - int'(FP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [55:0] pc1_perm(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) begin
            r[55 - i] = x[64 - int'(PC1_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] pc2_perm(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) begin
            r[47 - i] = x[56 - int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] expand(input logic [31:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) begin
            r[47 - i] = x[32 - int'(EXP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [31:0] p_perm(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[31 - i] = x[32 - int'(P_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [4:0] s);
        logic [55:0] w;
        w = {v, v} << s;
        return w[55:28];
    endfunction

    // Round key for one round: pure wiring of the DES key
    function automatic logic [47:0] sched_subkey(input logic [63:0] key, input logic [3:0] rnd);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        cd = pc1_perm(key);
        c  = rotl28(cd[55:28], ROT_SUM_TAB[rnd]);
        d  = rotl28(cd[27:0], ROT_SUM_TAB[rnd]);
        return pc2_perm({c, d});
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] rh, input logic [47:0] k);
        logic [47:0] x;
        logic [5:0]  six;
        logic [31:0] s;
        x = expand(rh) ^ k;
        for (int b = 0; b < 8; b++) begin
            six = x[47 - 6 * b -: 6];
            s[31 - 4 * b -: 4] = SBOX_TAB[b][{six[5], six[0], six[4:1]}];
        end
        return p_perm(s);
    endfunction

endpackage

// ===== src/desx_round.sv =====
// One registered DES round stage: Feistel function, swap and valid bit.
`timescale 1ns / 1ps

module desx_round
    import desx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [31:0] i_l,
    input  logic [31:0] i_r,
    input  logic [47:0] i_subkey,
    output logic        o_valid,
    output logic [31:0] o_l,
    output logic [31:0] o_r
);

    logic        r_valid;
    logic [31:0] r_l;
    logic [31:0] r_r;
    logic [31:0] n_r;

    assign n_r = i_l ^ feistel(i_r, i_subkey);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_l <= i_r;
            r_r <= n_r;
        end
    end

    assign o_valid = r_valid;
    assign o_l     = r_l;
    assign o_r     = r_r;

endmodule

// ===== src/desx_block_cipher.sv =====
// Top level of the DESX cipher: config registers, input stage, 16 rounds, output stage.
`timescale 1ns / 1ps
//
// Usage:
//   Configuration: write the pre-whitening key (index 0), DES key (1), post-whitening
//   key (2) and mode (3, bit 0: 1 = decrypt) on the cfg channel while no block is in
//   flight. o_cfg_ready is always high; a write completes on every valid beat.
//   Data in: a 64-bit block is taken on a beat where i_valid is high and o_stall low.
//   Data out: o_result_block is valid while o_valid is high and is taken when i_stall
//   is low; it holds while stalled.
//   Pipeline: whitening + IP stage, one stage per DES round, FP + whitening output
//   stage: 18 registers, the first loaded on the accepting edge.
//   Throughput: one block per cycle while not stalled; round keys are wired from the
//   stored DES key, so nothing is shared between blocks.
//   Stall: while the output register holds an untaken result and i_stall is high, the
//   whole pipeline freezes and o_stall is raised; no beat is lost or repeated.
//   Reset: all key registers clear to zero, mode to encrypt, and the pipeline empties.
//
module desx_block_cipher
    import desx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_block
);

    logic [63:0] r_pre_key;
    logic [63:0] r_des_key;
    logic [63:0] r_post_key;
    logic        r_decrypt;

    logic        w_adv;
    logic [63:0] w_in_ip;

    logic        r_s0_valid;
    logic [31:0] r_s0_l;
    logic [31:0] r_s0_r;

    logic        w_valid [0:NUM_ROUNDS];
    logic [31:0] w_l     [0:NUM_ROUNDS];
    logic [31:0] w_r     [0:NUM_ROUNDS];

    logic        r_out_valid;
    logic [63:0] r_out_block;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_key  <= '0;
            r_des_key  <= '0;
            r_post_key <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRE_KEY:  r_pre_key  <= i_cfg_data;
                CFG_DES_KEY:  r_des_key  <= i_cfg_data;
                CFG_POST_KEY: r_post_key <= i_cfg_data;
                CFG_MODE:     r_decrypt  <= i_cfg_data[0];
            endcase
        end
    end

    // Advance unless the output register holds a stalled result
    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    assign w_in_ip = ip_perm(i_data_block ^ (r_decrypt ? r_post_key : r_pre_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_l <= w_in_ip[63:32];
            r_s0_r <= w_in_ip[31:0];
        end
    end

    assign w_valid[0] = r_s0_valid;
    assign w_l[0]     = r_s0_l;
    assign w_r[0]     = r_s0_r;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        logic [47:0] w_subkey;

        // Decrypt walks the round keys in reverse order
        assign w_subkey = r_decrypt ? sched_subkey(r_des_key, 4'(NUM_ROUNDS - 1 - g))
                                    : sched_subkey(r_des_key, 4'(g));

        desx_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_valid  (w_valid[g]),
            .i_l      (w_l[g]),
            .i_r      (w_r[g]),
            .i_subkey (w_subkey),
            .o_valid  (w_valid[g + 1]),
            .o_l      (w_l[g + 1]),
            .o_r      (w_r[g + 1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[NUM_ROUNDS];
        end
    end

    // Final swap is undone by feeding {R, L} into FP
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_block <= fp_perm({w_r[NUM_ROUNDS], w_l[NUM_ROUNDS]})
                         ^ (r_decrypt ? r_pre_key : r_post_key);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_block = r_out_block;

endmodule
